@@ design/gcd_euclid_unit_macros.svh @@
// Assertion macros shared by the gcd unit.
`ifndef GCD_EUCLID_UNIT_MACROS_SVH
`define GCD_EUCLID_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/gcd_pkg.sv @@
// Shared constants and controller/datapath interface types for the gcd unit.
`timescale 1ns / 1ps

package gcd_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int IO_WIDTH      = 32;
   localparam int SHIFT_WIDTH   = $clog2(OPERAND_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [IO_WIDTH-1:0]      io_word_type;
   typedef logic [SHIFT_WIDTH-1:0]   shift_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } gcd_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic finished;
   } gcd_stat_type;

endpackage

@@ design/gcd_dp.sv @@
// Datapath of the gcd unit: operand registers, binary gcd step and result register.
`timescale 1ns / 1ps

module gcd_dp (
   input  logic                 clock,
   input  gcd_pkg::io_word_type first_operand,
   input  gcd_pkg::io_word_type second_operand,
   input  gcd_pkg::gcd_cmd_type cmd,
   output gcd_pkg::gcd_stat_type stat,
   output gcd_pkg::io_word_type divisor_result,
   output logic                 both_zero
);
   import gcd_pkg::*;

   operand_type a_ff, a_in;
   operand_type b_ff, b_in;
   shift_type   k_ff, k_in;
   logic        zero_ff, zero_in;
   io_word_type result_ff, result_in;
   logic        flag_ff, flag_in;

   operand_type a_load, b_load, survivor, scaled;
   logic        a_zero, b_zero, a_ge_b;

   assign a_load = OPERAND_WIDTH'(first_operand);
   assign b_load = OPERAND_WIDTH'(second_operand);
   assign a_zero = (a_ff == '0);
   assign b_zero = (b_ff == '0);
   assign a_ge_b = (a_ff >= b_ff);
   assign stat.finished = a_zero | b_zero;

   // The nonzero survivor times the common power of two is the gcd.
   assign survivor = a_zero ? b_ff : a_ff;
   assign scaled   = survivor << k_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         a_in    = a_load;
         b_in    = b_load;
         k_in    = '0;
         zero_in = (a_load == '0) && (b_load == '0);
      end else if (cmd.step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            // pull a common factor of two out of both
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + SHIFT_WIDTH'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ge_b) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   assign result_in = cmd.emit ? IO_WIDTH'(scaled) : result_ff;
   assign flag_in   = cmd.emit ? zero_ff : flag_ff;

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      zero_ff   <= zero_in;
      result_ff <= result_in;
      flag_ff   <= flag_in;
   end

   assign divisor_result = result_ff;
   assign both_zero      = flag_ff;

endmodule

@@ design/gcd_ctrl.sv @@
// Controller of the gcd unit: sequences load, step and result hand-off.
`timescale 1ns / 1ps

module gcd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  gcd_pkg::gcd_stat_type stat,
   output gcd_pkg::gcd_cmd_type  cmd
);
   import gcd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } gcd_state_type;

   gcd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.finished) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/gcd_euclid_unit.sv @@
// Top level of the gcd unit: controller, datapath and checks.
`timescale 1ns / 1ps
`include "gcd_euclid_unit_macros.svh"

// Greatest common divisor of two unsigned operands. One item is in flight at
// a time. The request transfer edge loads the operands. The unit then runs one
// binary gcd step per cycle. Every halving drops a bit, and every subtract
// leaves an even difference that the next step halves. That makes at most
// about 4*OPERAND_WIDTH steps. The controller then sees the finish in ST_RUN,
// moves to ST_DONE and writes the output register once that register is free.
// The result sits in its own register, so the next request is taken while it
// waits for rsp_ready. Both operands zero give a result of 0 with
// rsp_both_zero set; one zero operand gives the other operand.
module gcd_euclid_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gcd_pkg::io_word_type req_first_operand,
   input  gcd_pkg::io_word_type req_second_operand,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gcd_pkg::io_word_type rsp_divisor_result,
   output logic                 rsp_both_zero
);
   import gcd_pkg::*;

   gcd_cmd_type  cmd;
   gcd_stat_type stat;

   gcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gcd_dp u_dp (
      .clock          (clock),
      .first_operand  (req_first_operand),
      .second_operand (req_second_operand),
      .cmd            (cmd),
      .stat           (stat),
      .divisor_result (rsp_divisor_result),
      .both_zero      (rsp_both_zero)
   );

   `GCD_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `GCD_ASSERT_NOW(a_emit_when_done, clock, reset, cmd.emit, stat.finished, "result written before iteration finished")
   `GCD_ASSERT_NOW(a_zero_flag_result, clock, reset, rsp_valid && rsp_both_zero, rsp_divisor_result == '0, "zero flag with nonzero result")

endmodule
